>>> rtl/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 24;
  localparam int PTR_W        = 24;
  localparam int TOP_W        = 25;
  localparam int SIZE_W       = 24;
  localparam int COUNT_W      = 16;
  localparam int PROD_W       = SIZE_W + COUNT_W;
  localparam int IDX_W        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_CALLOC  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_REUSED   = 3'd0,
    ST_EXTENDED = 3'd1,
    ST_KEPT     = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_BAD      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    RES_BAD,
    RES_NOSPACE,
    RES_KEPT_NULL,
    RES_KEEP_PTR,
    RES_REUSED,
    RES_EXTENDED
  } res_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOOKUP,
    S_FIT,
    S_EXTEND,
    S_FREE_OLD,
    S_DONE
  } state_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [SIZE_W-1:0]  request_size;
    logic [COUNT_W-1:0] element_count;
    logic [PTR_W-1:0]   user_pointer;
  } req_t;

  typedef struct packed {
    logic [PTR_W-1:0]  result_pointer;
    status_t           status;
    logic              zero_fill;
    logic [PTR_W-1:0]  copy_source;
    logic [SIZE_W-1:0] copy_length;
  } rsp_t;

  typedef struct packed {
    logic [PTR_W-1:0]  base;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  typedef struct packed {
    logic      latch;
    logic      scan_start;
    logic      scan_run;
    logic      scan_fit;
    logic      wr_hit_busy;
    logic      wr_hit_free;
    logic      save_old;
    logic      extend;
    logic      wr_old_free;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    sz_zero;
    logic    p_zero;
    logic    total_zero;
    logic    total_big;
    logic    hit;
    logic    scan_end;
    logic    hit_free;
    logic    hit_fits;
    logic    ext_ok;
    logic    old_valid;
    logic    out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/ffba_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ffba_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ffba_pkg::req_t                req,
  input  logic                          cfg_valid,
  input  logic [ffba_pkg::TOP_W-1:0]    cfg_data,
  input  ffba_pkg::cmd_t                cmd,
  output ffba_pkg::sts_t                sts,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output ffba_pkg::rsp_t                rsp
);

  localparam int EXT_W = ffba_pkg::TOP_W + 1;

  ffba_pkg::entry_t mem [ffba_pkg::MAX_BLOCKS];

  ffba_pkg::req_t                   cur;
  logic [ffba_pkg::PROD_W-1:0]      total;
  logic [ffba_pkg::TOP_W-1:0]       heap_limit;
  logic [ffba_pkg::TOP_W-1:0]       heap_top;
  logic [ffba_pkg::CNT_W-1:0]       block_count;
  logic [ffba_pkg::CNT_W-1:0]       scan_idx;
  logic                             rd_vld;
  logic [ffba_pkg::IDX_W-1:0]       rd_idx;
  ffba_pkg::entry_t                 rd_entry;
  logic [ffba_pkg::PTR_W-1:0]       res_ptr;
  ffba_pkg::entry_t                 old_entry;
  logic [ffba_pkg::IDX_W-1:0]       old_idx;
  logic                             old_valid;

  logic [ffba_pkg::SIZE_W-1:0]      size_req;
  logic                             issue;
  logic                             match;
  logic [ffba_pkg::PTR_W:0]         rd_payload;
  logic [EXT_W-1:0]                 ext_payload;
  logic [EXT_W-1:0]                 ext_end;
  logic                             ext_ok;
  logic                             wr_en;
  logic [ffba_pkg::IDX_W-1:0]       wr_addr;
  ffba_pkg::entry_t                 wr_data;
  logic                             out_free;
  logic                             copy_on;

  assign size_req = (cur.opcode == ffba_pkg::OP_CALLOC) ?
                    total[ffba_pkg::SIZE_W-1:0] : cur.request_size;
  assign issue    = cmd.scan_run && (scan_idx < block_count);
  assign rd_payload = {1'b0, rd_entry.base} +
                      (ffba_pkg::PTR_W+1)'(ffba_pkg::HEADER_BYTES);

  always_comb begin
    if (cmd.scan_fit) begin
      match = rd_entry.free && (rd_entry.size >= size_req);
    end else begin
      match = (rd_payload == {1'b0, cur.user_pointer});
    end
  end

  assign ext_payload = {1'b0, heap_top} + EXT_W'(ffba_pkg::HEADER_BYTES);
  assign ext_end     = ext_payload + EXT_W'(size_req);
  assign ext_ok      = (block_count < ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS)) &&
                       (ext_end <= {1'b0, heap_limit}) &&
                       (ext_payload[EXT_W-1:ffba_pkg::PTR_W] == '0) &&
                       (ext_payload != '0);

  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    sts.op         = cur.opcode;
    sts.sz_zero    = (cur.request_size == '0);
    sts.p_zero     = (cur.user_pointer == '0);
    sts.total_zero = (total == '0);
    sts.total_big  = (total[ffba_pkg::PROD_W-1:ffba_pkg::SIZE_W] != '0);
    sts.hit        = rd_vld && match;
    sts.scan_end   = !rd_vld && !(scan_idx < block_count);
    sts.hit_free   = rd_entry.free;
    sts.hit_fits   = (rd_entry.size >= cur.request_size);
    sts.ext_ok     = ext_ok;
    sts.old_valid  = old_valid;
    sts.out_free   = out_free;
  end

  // single table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = rd_entry;
    if (cmd.wr_hit_busy) begin
      wr_en        = 1'b1;
      wr_data.free = 1'b0;
    end else if (cmd.wr_hit_free) begin
      wr_en        = 1'b1;
      wr_data.free = 1'b1;
    end else if (cmd.extend) begin
      wr_en        = 1'b1;
      wr_addr      = block_count[ffba_pkg::IDX_W-1:0];
      wr_data.base = heap_top[ffba_pkg::PTR_W-1:0];
      wr_data.size = size_req;
      wr_data.free = 1'b0;
    end else if (cmd.wr_old_free) begin
      wr_en        = 1'b1;
      wr_addr      = old_idx;
      wr_data      = old_entry;
      wr_data.free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_entry <= mem[scan_idx[ffba_pkg::IDX_W-1:0]];
    rd_idx   <= scan_idx[ffba_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit  <= ffba_pkg::TOP_W'(1 << ffba_pkg::PTR_W);
      heap_top    <= '0;
      block_count <= '0;
      scan_idx    <= '0;
      rd_vld      <= 1'b0;
      old_valid   <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        heap_limit <= cfg_data;
      end
      if (cmd.scan_start) begin
        scan_idx <= '0;
        rd_vld   <= 1'b0;
      end else begin
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
        rd_vld <= issue;
      end
      if (cmd.extend) begin
        block_count <= block_count + 1'b1;
        heap_top    <= ext_end[ffba_pkg::TOP_W-1:0];
      end
      if (cmd.latch) begin
        old_valid <= 1'b0;
      end else if (cmd.save_old) begin
        old_valid <= 1'b1;
      end
      if (cmd.res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur   <= req;
      total <= req.element_count * req.request_size;
    end
    if (cmd.save_old) begin
      old_entry <= rd_entry;
      old_idx   <= rd_idx;
    end
    if (cmd.wr_hit_busy) begin
      res_ptr <= rd_payload[ffba_pkg::PTR_W-1:0];
    end else if (cmd.extend) begin
      res_ptr <= ext_payload[ffba_pkg::PTR_W-1:0];
    end
  end

  assign copy_on = old_valid && (cur.opcode == ffba_pkg::OP_REALLOC);

  // result word
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp.result_pointer <= '0;
      rsp.zero_fill      <= 1'b0;
      rsp.copy_source    <= '0;
      rsp.copy_length    <= '0;
      case (cmd.res_kind)
        ffba_pkg::RES_NOSPACE: begin
          rsp.status <= ffba_pkg::ST_NOSPACE;
        end
        ffba_pkg::RES_KEPT_NULL: begin
          rsp.status <= ffba_pkg::ST_KEPT;
        end
        ffba_pkg::RES_KEEP_PTR: begin
          rsp.status         <= ffba_pkg::ST_KEPT;
          rsp.result_pointer <= cur.user_pointer;
        end
        ffba_pkg::RES_REUSED, ffba_pkg::RES_EXTENDED: begin
          rsp.status <= (cmd.res_kind == ffba_pkg::RES_REUSED) ?
                        ffba_pkg::ST_REUSED : ffba_pkg::ST_EXTENDED;
          rsp.result_pointer <= res_ptr;
          rsp.zero_fill      <= (cur.opcode == ffba_pkg::OP_CALLOC);
          if (copy_on) begin
            rsp.copy_source <= cur.user_pointer;
            rsp.copy_length <= old_entry.size;
          end
        end
        default: begin
          rsp.status <= ffba_pkg::ST_BAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/ffba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ffba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ffba_pkg::sts_t sts,
  output ffba_pkg::cmd_t cmd
);

  ffba_pkg::state_t    state;
  ffba_pkg::state_t    state_next;
  ffba_pkg::res_kind_t res_kind;
  ffba_pkg::res_kind_t res_kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffba_pkg::S_IDLE;
      res_kind <= ffba_pkg::RES_BAD;
    end else begin
      state    <= state_next;
      res_kind <= res_kind_next;
    end
  end

  // next state
  always_comb begin
    state_next    = state;
    res_kind_next = res_kind;
    case (state)
      ffba_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = ffba_pkg::S_DECODE;
        end
      end
      ffba_pkg::S_DECODE: begin
        case (sts.op)
          ffba_pkg::OP_ALLOC: begin
            if (sts.sz_zero) begin
              state_next    = ffba_pkg::S_DONE;
              res_kind_next = ffba_pkg::RES_BAD;
            end else begin
              state_next = ffba_pkg::S_FIT;
            end
          end
          ffba_pkg::OP_FREE: begin
            if (sts.p_zero) begin
              state_next    = ffba_pkg::S_DONE;
              res_kind_next = ffba_pkg::RES_KEPT_NULL;
            end else begin
              state_next = ffba_pkg::S_LOOKUP;
            end
          end
          ffba_pkg::OP_REALLOC: begin
            if (!sts.p_zero) begin
              state_next = ffba_pkg::S_LOOKUP;
            end else if (sts.sz_zero) begin
              state_next    = ffba_pkg::S_DONE;
              res_kind_next = ffba_pkg::RES_BAD;
            end else begin
              state_next = ffba_pkg::S_FIT;
            end
          end
          default: begin
            if (sts.total_zero) begin
              state_next    = ffba_pkg::S_DONE;
              res_kind_next = ffba_pkg::RES_BAD;
            end else if (sts.total_big) begin
              state_next    = ffba_pkg::S_DONE;
              res_kind_next = ffba_pkg::RES_NOSPACE;
            end else begin
              state_next = ffba_pkg::S_FIT;
            end
          end
        endcase
      end
      ffba_pkg::S_LOOKUP: begin
        if (sts.hit) begin
          if (sts.op == ffba_pkg::OP_FREE) begin
            state_next    = ffba_pkg::S_DONE;
            res_kind_next = ffba_pkg::RES_KEPT_NULL;
          end else if (sts.hit_free) begin
            state_next    = ffba_pkg::S_DONE;
            res_kind_next = ffba_pkg::RES_BAD;
          end else if (sts.hit_fits) begin
            state_next    = ffba_pkg::S_DONE;
            res_kind_next = ffba_pkg::RES_KEEP_PTR;
          end else begin
            state_next = ffba_pkg::S_FIT;
          end
        end else if (sts.scan_end) begin
          state_next    = ffba_pkg::S_DONE;
          res_kind_next = ffba_pkg::RES_BAD;
        end
      end
      ffba_pkg::S_FIT: begin
        if (sts.hit) begin
          res_kind_next = ffba_pkg::RES_REUSED;
          state_next    = sts.old_valid ? ffba_pkg::S_FREE_OLD : ffba_pkg::S_DONE;
        end else if (sts.scan_end) begin
          state_next = ffba_pkg::S_EXTEND;
        end
      end
      ffba_pkg::S_EXTEND: begin
        if (sts.ext_ok) begin
          res_kind_next = ffba_pkg::RES_EXTENDED;
          state_next    = sts.old_valid ? ffba_pkg::S_FREE_OLD : ffba_pkg::S_DONE;
        end else begin
          res_kind_next = ffba_pkg::RES_NOSPACE;
          state_next    = ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_FREE_OLD: begin
        state_next = ffba_pkg::S_DONE;
      end
      ffba_pkg::S_DONE: begin
        if (sts.out_free) begin
          state_next = ffba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ffba_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    req_ready       = 1'b0;
    cmd             = '0;
    cmd.res_kind    = res_kind;
    case (state)
      ffba_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.latch = req_valid;
      end
      ffba_pkg::S_DECODE: begin
        cmd.scan_start = 1'b1;
      end
      ffba_pkg::S_LOOKUP: begin
        cmd.scan_run = 1'b1;
        if (sts.hit) begin
          if (sts.op == ffba_pkg::OP_FREE) begin
            cmd.wr_hit_free = 1'b1;
          end else if (!sts.hit_free && !sts.hit_fits) begin
            cmd.save_old   = 1'b1;
            cmd.scan_start = 1'b1;
          end
        end
      end
      ffba_pkg::S_FIT: begin
        cmd.scan_run    = 1'b1;
        cmd.scan_fit    = 1'b1;
        cmd.wr_hit_busy = sts.hit;
      end
      ffba_pkg::S_EXTEND: begin
        cmd.scan_fit = 1'b1;
        cmd.extend   = sts.ext_ok;
      end
      ffba_pkg::S_FREE_OLD: begin
        cmd.wr_old_free = 1'b1;
      end
      ffba_pkg::S_DONE: begin
        cmd.res_load = sts.out_free;
      end
      default: begin
        cmd.res_load = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/first_fit_block_allocator_top.sv
// First-fit heap allocator over a 64-entry block table kept in address order.
// Request channel (req_valid/req_ready/req) takes one word: opcode, size,
// element count and user pointer. Response channel (rsp_valid/rsp_ready/rsp)
// returns one word per request: pointer, status, zero-fill flag, copy range.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes the heap limit; it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. One request is worked on at a time.
// Trivial requests need no table scan, most requests scan the table once
// and a realloc may scan it twice. The table scan reads one entry per cycle
// from a memory with one read port and one write port. The next request is
// accepted in the cycle after the response word is loaded.
// A new request is accepted while the previous response still waits; the
// block then holds in its last state until the output register is free.
// Reset (synchronous, active high) empties the table, sets the heap top to 0
// and the heap limit to 16777216; table contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  ffba_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output ffba_pkg::rsp_t             rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ffba_pkg::TOP_W-1:0] cfg_data
);

  ffba_pkg::cmd_t cmd;
  ffba_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffba_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

>>> dv/tb_first_fit_block_allocator_top.sv
`timescale 1ns / 1ps

module tb_first_fit_block_allocator_top;
  import ffba_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam logic [TOP_W-1:0] FULL_LIMIT = 25'd16777216;

  class heap_table_model;
    logic [PTR_W-1:0]  blk_base [MAX_BLOCKS];
    logic [SIZE_W-1:0] blk_size [MAX_BLOCKS];
    bit                blk_free [MAX_BLOCKS];
    int unsigned       blk_count = 0;
    longint unsigned   top = 0;
    longint unsigned   limit = 16777216;
    rsp_t              replies [$];
    int                errors = 0;

    function int find_block(longint unsigned p);
      for (int i = 0; i < blk_count; i++) begin
        if (longint'(blk_base[i]) + HEADER_BYTES == p) return i;
      end
      return -1;
    endfunction

    // first fit over the table, else bump the heap top
    function longint unsigned grab(longint unsigned sz, output status_t st);
      longint unsigned payload;
      for (int i = 0; i < blk_count; i++) begin
        if (blk_free[i] && blk_size[i] >= sz) begin
          blk_free[i] = 1'b0;
          st = ST_REUSED;
          return longint'(blk_base[i]) + HEADER_BYTES;
        end
      end
      payload = top + HEADER_BYTES;
      if (blk_count >= MAX_BLOCKS || payload + sz > limit ||
          payload > 64'hFF_FFFF || payload == 0) begin
        st = ST_NOSPACE;
        return 0;
      end
      blk_base[blk_count] = top[PTR_W-1:0];
      blk_size[blk_count] = sz[SIZE_W-1:0];
      blk_free[blk_count] = 1'b0;
      blk_count++;
      top = payload + sz;
      st = ST_EXTENDED;
      return payload;
    endfunction

    function void apply_request(req_t r);
      rsp_t            e;
      status_t         st;
      int              k;
      longint unsigned ptr;
      longint unsigned total;
      e = '0;
      e.status = ST_BAD;
      case (r.opcode)
        OP_ALLOC: begin
          if (r.request_size != 0) begin
            ptr = grab(r.request_size, st);
            e.result_pointer = ptr[PTR_W-1:0];
            e.status = st;
          end
        end
        OP_FREE: begin
          if (r.user_pointer == 0) begin
            e.status = ST_KEPT;
          end else begin
            k = find_block(r.user_pointer);
            if (k >= 0) begin
              blk_free[k] = 1'b1;
              e.status = ST_KEPT;
            end
          end
        end
        OP_REALLOC: begin
          if (r.user_pointer == 0) begin
            if (r.request_size != 0) begin
              ptr = grab(r.request_size, st);
              e.result_pointer = ptr[PTR_W-1:0];
              e.status = st;
            end
          end else begin
            k = find_block(r.user_pointer);
            if (k >= 0 && !blk_free[k]) begin
              if (blk_size[k] >= r.request_size) begin
                e.result_pointer = r.user_pointer;
                e.status = ST_KEPT;
              end else begin
                ptr = grab(r.request_size, st);
                e.result_pointer = ptr[PTR_W-1:0];
                e.status = st;
                if (ptr != 0) begin
                  e.copy_source = r.user_pointer;
                  e.copy_length = blk_size[k];
                  blk_free[k] = 1'b1;
                end
              end
            end
          end
        end
        OP_CALLOC: begin
          total = r.element_count;
          total = total * r.request_size;
          if (total == 0) begin
            e.status = ST_BAD;
          end else if (total > 64'hFF_FFFF) begin
            e.status = ST_NOSPACE;
          end else begin
            ptr = grab(total, st);
            e.result_pointer = ptr[PTR_W-1:0];
            e.status = st;
            e.zero_fill = (ptr != 0);
          end
        end
      endcase
      replies.push_back(e);
    endfunction

    function void check_reply(rsp_t a);
      rsp_t e;
      if (replies.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h", $time, a);
        errors++;
        return;
      end
      e = replies.pop_front();
      if (a.result_pointer !== e.result_pointer) begin
        $display("%0t result_pointer: expected %h, actual %h", $time,
                 e.result_pointer, a.result_pointer);
        errors++;
      end
      if (a.status !== e.status) begin
        $display("%0t status: expected %0d, actual %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.zero_fill !== e.zero_fill) begin
        $display("%0t zero_fill: expected %b, actual %b", $time, e.zero_fill, a.zero_fill);
        errors++;
      end
      if (a.copy_source !== e.copy_source) begin
        $display("%0t copy_source: expected %h, actual %h", $time,
                 e.copy_source, a.copy_source);
        errors++;
      end
      if (a.copy_length !== e.copy_length) begin
        $display("%0t copy_length: expected %h, actual %h", $time,
                 e.copy_length, a.copy_length);
        errors++;
      end
    endfunction

    // mostly live payload offsets, some near misses and random values
    function logic [PTR_W-1:0] pick_pointer();
      int i;
      if (blk_count == 0 || $urandom_range(99) < 10) return PTR_W'($urandom);
      i = $urandom_range(blk_count - 1);
      if ($urandom_range(99) < 8) return PTR_W'(blk_base[i] + HEADER_BYTES + 1);
      return PTR_W'(blk_base[i] + HEADER_BYTES);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TOP_W-1:0] cfg_data = '0;

  heap_table_model model = new;
  int              req_idle_pct = 0;
  int              rsp_idle_pct = 0;
  int              quiet_cycles = 0;

  first_fit_block_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) model.check_reply(rsp);
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t make_req(opcode_t op, logic [SIZE_W-1:0] sz,
                                    logic [COUNT_W-1:0] cnt, logic [PTR_W-1:0] p);
    req_t r;
    r.opcode = op;
    r.request_size = sz;
    r.element_count = cnt;
    r.user_pointer = p;
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] draw_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) return '0;
    if (pick < 82) return SIZE_W'($urandom_range(1, 300));
    if (pick < 95) return SIZE_W'($urandom_range(301, 70000));
    return SIZE_W'($urandom);
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    r.opcode = OP_ALLOC;
    r.request_size = draw_size();
    r.element_count = COUNT_W'($urandom);
    r.user_pointer = PTR_W'($urandom);
    if (pick < 5) begin
      r.opcode = opcode_t'($urandom_range(3));
      r.request_size = SIZE_W'($urandom);
    end else if (pick < 35) begin
      r.opcode = OP_ALLOC;
    end else if (pick < 60) begin
      r.opcode = OP_FREE;
      r.user_pointer = ($urandom_range(99) < 5) ? '0 : model.pick_pointer();
    end else if (pick < 85) begin
      r.opcode = OP_REALLOC;
      r.user_pointer = ($urandom_range(99) < 10) ? '0 : model.pick_pointer();
    end else begin
      r.opcode = OP_CALLOC;
      if ($urandom_range(99) < 85) begin
        r.element_count = COUNT_W'($urandom_range(0, 16));
        r.request_size = SIZE_W'($urandom_range(0, 64));
      end
    end
    return r;
  endfunction

  task automatic issue_request(req_t r);
    while ($urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    model.apply_request(r);
    @(negedge clk);
  endtask

  task automatic write_heap_limit(logic [TOP_W-1:0] v);
    req_valid <= 1'b0;
    while (model.replies.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    model.limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int n);
    repeat (n) issue_request(random_request());
  endtask

  initial begin
    longint unsigned mid_limit;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    req_idle_pct = 12;
    rsp_idle_pct = 86;
    write_heap_limit(FULL_LIMIT);

    issue_request(make_req(OP_ALLOC, 24'd0, 16'd0, 24'd0));
    issue_request(make_req(OP_ALLOC, 24'hFF_FFFF, 16'hFFFF, 24'hFF_FFFF));
    issue_request(make_req(OP_ALLOC, 24'd100, 16'd0, 24'd0));
    issue_request(make_req(OP_ALLOC, 24'd50, 16'd0, 24'd0));
    issue_request(make_req(OP_FREE, 24'd0, 16'd0, 24'd0));
    issue_request(make_req(OP_FREE, 24'd0, 16'd0, 24'd25));
    issue_request(make_req(OP_FREE, 24'hFF_FFFF, 16'hFFFF, 24'hFF_FFFF));
    issue_request(make_req(OP_FREE, 24'd0, 16'd0, 24'd24));
    issue_request(make_req(OP_FREE, 24'd0, 16'd0, 24'd24));
    issue_request(make_req(OP_ALLOC, 24'd80, 16'd0, 24'd0));
    issue_request(make_req(OP_REALLOC, 24'd0, 16'd0, 24'd0));
    issue_request(make_req(OP_REALLOC, 24'd10, 16'd0, 24'd0));
    issue_request(make_req(OP_REALLOC, 24'd5, 16'd0, 24'd999));
    issue_request(make_req(OP_REALLOC, 24'd0, 16'd0, 24'd148));
    issue_request(make_req(OP_REALLOC, 24'd50, 16'd0, 24'd148));
    issue_request(make_req(OP_REALLOC, 24'd200, 16'd0, 24'd148));
    issue_request(make_req(OP_REALLOC, 24'd10, 16'd0, 24'd148));
    issue_request(make_req(OP_CALLOC, 24'd7, 16'd0, 24'd0));
    issue_request(make_req(OP_CALLOC, 24'd0, 16'd5, 24'd0));
    issue_request(make_req(OP_CALLOC, 24'hFF_FFFF, 16'hFFFF, 24'd0));
    issue_request(make_req(OP_CALLOC, 24'd10, 16'd4, 24'd0));
    issue_request(make_req(OP_CALLOC, 24'd256, 16'hFFFF, 24'd0));
    issue_request(make_req(OP_REALLOC, 24'hFF_FFFF, 16'd0, 24'd24));

    // new top lands exactly on the limit, then nothing more fits
    write_heap_limit(TOP_W'(model.top + HEADER_BYTES + 76));
    issue_request(make_req(OP_ALLOC, 24'd76, 16'd0, 24'd0));
    issue_request(make_req(OP_ALLOC, 24'd1, 16'd0, 24'd0));

    write_heap_limit(FULL_LIMIT);
    run_random(450);

    req_idle_pct = 86;
    rsp_idle_pct = 12;
    write_heap_limit('0);
    run_random(150);
    mid_limit = model.top + 2000;
    write_heap_limit((mid_limit > FULL_LIMIT) ? FULL_LIMIT : TOP_W'(mid_limit));
    run_random(200);

    req_idle_pct = 0;
    rsp_idle_pct = 0;
    write_heap_limit(FULL_LIMIT);
    run_random(400);
    req_valid <= 1'b0;

    while (model.replies.size() != 0) @(posedge clk);
    repeat (2 * MAX_BLOCKS + 8) @(posedge clk);
    if (model.errors == 0 && model.replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
